>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define TDPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// check on every clock edge, reset included
`define TDPT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

>>> hdl/tdpt_pkg.sv
// Shared types and constants for the trial division prime test
package tdpt_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_DIV,
        BK_CHECK,
        BK_DONE
    } back_state_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hdl/tdpt_queue.sv
// Small register queue between the front and back parts
module tdpt_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                rd_en,
    output logic [WIDTH-1:0]    rd_data,
    output tdpt_pkg::q_stat_t   stat
);
    import tdpt_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    always_comb
    begin
        stat.full   = (cnt_reg == CNT_FULL);
        stat.empty  = (cnt_reg == '0);
        do_wr       = wr_en && !stat.full;
        do_rd       = rd_en && !stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        rd_data = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/tdpt_front.sv
// Front part: accept words and mark those that need no division
module tdpt_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                        last_element,
    input  logic                        push,
    output logic                        full,
    output logic                        q_push,
    output logic [VALUE_BITS+1:0]       q_data,
    input  tdpt_pkg::q_stat_t           q_stat
);
    import tdpt_pkg::*;

    logic                  vld_reg, vld_next;
    logic [VALUE_BITS+1:0] word_reg;
    logic                  accept;
    logic                  trivial;

    always_comb
    begin
        full     = vld_reg && q_stat.full;
        accept   = push && !full;
        trivial  = value[VALUE_BITS-1] || (value[VALUE_BITS-1:1] == '0);
        q_push   = vld_reg;
        q_data   = word_reg;
        vld_next = accept || (vld_reg && q_stat.full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= {trivial, last_element, value};
        end
    end

endmodule

>>> hdl/tdpt_back.sv
// Back part: trial division over a bit-serial divider and the result register
module tdpt_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         q_pop,
    input  logic [VALUE_BITS+1:0]        q_data,
    input  tdpt_pkg::q_stat_t            q_stat,
    output logic                         is_prime,
    output logic signed [VALUE_BITS-1:0] tested_value,
    output logic                         end_of_run,
    output logic                         empty,
    input  logic                         pop
);
    import tdpt_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] FIRST_DIV = VALUE_BITS'(2);

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  prime_reg, prime_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  out_prime_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_last_reg;
    logic                  out_load;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        prime_next = prime_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        shifted    = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff       = shifted - {1'b0, div_reg};

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    val_next   = q_data[VALUE_BITS-1:0];
                    last_next  = q_data[VALUE_BITS];
                    div_next   = FIRST_DIV;
                    quo_next   = q_data[VALUE_BITS-1:0];
                    rem_next   = '0;
                    cnt_next   = CNT_LAST;
                    prime_next = 1'b0;
                    state_next = q_data[VALUE_BITS+1] ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (!diff[VALUE_BITS])
                begin
                    rem_next = diff[VALUE_BITS-1:0];
                    quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[VALUE_BITS-1:0];
                    quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (div_reg > quo_reg)
                begin
                    prime_next = 1'b1;
                    state_next = BK_DONE;
                end
                else if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    state_next = BK_DONE;
                end
                else
                begin
                    div_next   = div_reg + 1'b1;
                    quo_next   = val_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_LAST;
                    state_next = BK_DIV;
                end
            end
            BK_DONE:
            begin
                if (!out_vld_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_vld_next = out_load || (out_vld_reg && !pop);
        empty        = !out_vld_reg;
        is_prime     = out_prime_reg;
        tested_value = out_value_reg;
        end_of_run   = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        last_reg  <= last_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
        if (out_load)
        begin
            out_prime_reg <= prime_reg;
            out_value_reg <= val_reg;
            out_last_reg  <= last_reg;
        end
    end

endmodule

>>> hdl/trial_division_prime_test.sv
// Negative values, zero and one skip the divider and are marked not prime.
// Otherwise each trial divisor runs through the one-bit-a-cycle divider and a check step,
// and up to floor(sqrt(value)) divisors run, all of them for a prime.
// Words are tested one at a time; a two-word queue and the result register let
// the input side keep taking words while a result waits.
// Reset clears all control state at once; no clearing pass follows.
module trial_division_prime_test #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last_element,
    input  logic                         push,
    output logic                         full,
    output logic                         is_prime,
    output logic signed [VALUE_BITS-1:0] tested_value,
    output logic                         end_of_run,
    output logic                         empty,
    input  logic                         pop
);
    import tdpt_pkg::*;

    localparam int WORD_BITS = VALUE_BITS + 2;

    logic                 q_push;
    logic                 q_pop;
    logic [WORD_BITS-1:0] q_wr_data;
    logic [WORD_BITS-1:0] q_rd_data;
    q_stat_t              q_stat;

    tdpt_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last_element (last_element),
        .push         (push),
        .full         (full),
        .q_push       (q_push),
        .q_data       (q_wr_data),
        .q_stat       (q_stat)
    );

    tdpt_queue #(
        .WIDTH (WORD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    tdpt_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_pop        (q_pop),
        .q_data       (q_rd_data),
        .q_stat       (q_stat),
        .is_prime     (is_prime),
        .tested_value (tested_value),
        .end_of_run   (end_of_run),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

>>> hdl/tdpt_checker.sv
// Port-level checks for the trial division prime test, bound to the top level
`include "assert_macros.svh"

module tdpt_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         full,
    input logic                         is_prime,
    input logic signed [VALUE_BITS-1:0] tested_value,
    input logic                         end_of_run,
    input logic                         empty,
    input logic                         pop
);

    `TDPT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (empty && !full))

    `TDPT_ASSERT(a_hold_result, (!empty && !pop) |=> (!empty && $stable(is_prime) && $stable(tested_value) && $stable(end_of_run)))

    `TDPT_ASSERT(a_prime_above_one, (!empty && is_prime) |-> (tested_value > 1))

    `TDPT_ASSERT(a_even_prime_is_two, (!empty && is_prime && !tested_value[0]) |-> (tested_value == 2))

endmodule

bind trial_division_prime_test tdpt_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .is_prime     (is_prime),
    .tested_value (tested_value),
    .end_of_run   (end_of_run),
    .empty        (empty),
    .pop          (pop)
);
